// ----- design/nnbs_pkg.sv -----
// ----------------------------------------------------------------------------
// nnbs_pkg
// Shared types and constants of the nearest-neighbor bitmap scaler: field
// widths, configuration register indexes and reset values, controller states
// and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package nnbs_pkg;

	// Field widths fixed by the item formats
	localparam int PIXEL_W     = 16;
	localparam int LOAD_IDX_W  = 17;
	localparam int DEST_W      = 25;
	localparam int DIM_W       = 12;
	localparam int PITCH_W     = 13;
	localparam int ACC_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 48;
	localparam int M_TUSER_W   = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_COL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ROW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PITCH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_ROW_GAP   = 3'd7;

	// Configuration reset values
	localparam logic [DIM_W-1:0]   RST_START_COL      = 12'd0;
	localparam logic [DIM_W-1:0]   RST_START_ROW      = 12'd0;
	localparam logic [DIM_W-1:0]   RST_VISIBLE_WIDTH  = 12'd320;
	localparam logic [DIM_W-1:0]   RST_VISIBLE_HEIGHT = 12'd224;
	localparam logic [DIM_W-1:0]   RST_OUT_WIDTH      = 12'd240;
	localparam logic [DIM_W-1:0]   RST_OUT_HEIGHT     = 12'd160;
	localparam logic [PITCH_W-1:0] RST_SOURCE_PITCH   = 13'd320;
	localparam logic [DIM_W-1:0]   RST_DEST_ROW_GAP   = 12'd0;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_READ,
		ST_OUT
	} nnbs_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic ram_we;
		logic start_frame;
		logic step_load;
		logic mul_en;
		logic add_en;
		logic out_load;
	} nnbs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic frame_running;
		logic div_busy;
	} nnbs_sts_t;

endpackage

// ----- design/nnbs_ram.sv -----
// ----------------------------------------------------------------------------
// nnbs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module nnbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/nnbs_div.sv -----
// ----------------------------------------------------------------------------
// nnbs_div
// Restoring unsigned divider, one quotient bit per cycle. Busy is high while
// a started division runs and quotient is stable afterwards.
// ----------------------------------------------------------------------------
module nnbs_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [NUM_W-1:0] quotient,
	output logic             busy
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// Shift in the next dividend bit and trial-subtract the divisor
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			count_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			count_q <= count_q - 1'b1;
			if (count_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign busy     = busy_q;

	// A started division keeps the unit busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");

	// The count reaches zero exactly when the unit goes idle
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && count_q == CNT_W'(1)) |=> !busy_q)
		else $error("divider did not finish on last count");

	// Idle divider holds a zero count
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> count_q == '0)
		else $error("idle divider with nonzero count");

endmodule

// ----- design/nnbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnbs_ctrl
// Controller of the scaler: input handshake, sequencing of one emit item
// through frame setup, index multiply, index add, store read and result
// load, and the valid bit of the output register.
// ----------------------------------------------------------------------------
module nnbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_tvalid,
	input  logic                in_op,
	output logic                in_tready,
	output logic                out_tvalid,
	input  logic                out_tready,
	input  nnbs_pkg::nnbs_sts_t sts,
	output nnbs_pkg::nnbs_cmd_t cmd
);

	import nnbs_pkg::*;

	nnbs_state_t state_q, state_d;
	logic        out_valid_q;
	logic        in_accept;
	logic        slot_free;

	assign in_tready  = (state_q == ST_IDLE);
	assign in_accept  = in_tvalid && in_tready;
	assign slot_free  = !out_valid_q || out_tready;
	assign out_tvalid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && in_op) begin
					state_d = sts.frame_running ? ST_MUL : ST_START;
				end
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.ram_we      = in_accept && !in_op;
		unique case (state_q)
			ST_IDLE:  ;
			ST_START: cmd.start_frame = 1'b1;
			ST_DIV:   cmd.step_load   = !sts.div_busy;
			ST_MUL:   cmd.mul_en      = 1'b1;
			ST_ADD:   cmd.add_en      = 1'b1;
			ST_READ:  ;
			ST_OUT:   cmd.out_load    = slot_free;
		endcase
	end

	// State register and output valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is loaded only into a free or draining output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_tready))
		else $error("result overwrote a pending transfer");

	// An emit item blocks the input in the following cycle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_op) |=> !in_tready)
		else $error("input ready right after an emit transfer");

	// Waiting on the step division happens only inside a running frame
	a_div_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> sts.frame_running)
		else $error("step division outside a frame");

	// A loaded result is offered in the next cycle
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not offered");

endmodule

// ----- design/nnbs_dp.sv -----
// ----------------------------------------------------------------------------
// nnbs_dp
// Datapath of the scaler: configuration registers, step dividers, frame
// accumulators and counters, source index multiply-add, frame store and the
// payload of the output register.
// ----------------------------------------------------------------------------
module nnbs_dp #(
	parameter int STORE_DEPTH   = 131072,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nnbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nnbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  nnbs_pkg::nnbs_cmd_t                 cmd,
	output nnbs_pkg::nnbs_sts_t                 sts,
	input  logic [nnbs_pkg::LOAD_IDX_W-1:0]     load_index,
	input  logic [nnbs_pkg::PIXEL_W-1:0]        load_pixel,
	output logic [nnbs_pkg::PIXEL_W-1:0]        out_pixel,
	output logic [nnbs_pkg::DEST_W-1:0]         dest_address,
	output logic                                row_end,
	output logic                                frame_end,
	output logic                                outside_store
);

	import nnbs_pkg::*;

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int FB     = FRACTION_BITS;
	localparam int NUM_W  = DIM_W + FB;
	localparam int INT_W  = ACC_W - FB;
	localparam int PROD_W = INT_W + PITCH_W;
	localparam int IDX_W  = PROD_W + 1;

	// Configuration registers
	logic [DIM_W-1:0]   start_col_q, start_row_q, vis_w_q, vis_h_q;
	logic [DIM_W-1:0]   out_w_q, out_h_q, gap_q;
	logic [PITCH_W-1:0] pitch_q;

	// Frame state
	logic [NUM_W-1:0]   col_step_q, row_step_q;
	logic [ACC_W-1:0]   col_accum_q, row_accum_q;
	logic [DIM_W-1:0]   cols_left_q, rows_left_q;
	logic [DEST_W-1:0]  dest_q;
	logic               frame_running_q;

	// Index pipeline
	logic [PROD_W-1:0]  prod_s1;
	logic [INT_W-1:0]   col_int_s1;
	logic [IDX_W-1:0]   idx_s2;
	logic               outside_s2;
	logic [IDX_W-1:0]   idx_sum;

	logic [DIM_W-1:0]   ow, oh;
	logic [NUM_W-1:0]   col_quo, row_quo;
	logic               col_busy, row_busy;
	logic [PIXEL_W-1:0] rdata;
	logic               load_ok;
	logic [DIM_W-1:0]   cols_dec, rows_dec;
	logic               row_last, frame_last;
	logic [DEST_W-1:0]  dest_inc;

	// Treat a zero output size as one
	assign ow = (out_w_q == '0) ? DIM_W'(1) : out_w_q;
	assign oh = (out_h_q == '0) ? DIM_W'(1) : out_h_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q <= RST_START_COL;
			start_row_q <= RST_START_ROW;
			vis_w_q     <= RST_VISIBLE_WIDTH;
			vis_h_q     <= RST_VISIBLE_HEIGHT;
			out_w_q     <= RST_OUT_WIDTH;
			out_h_q     <= RST_OUT_HEIGHT;
			pitch_q     <= RST_SOURCE_PITCH;
			gap_q       <= RST_DEST_ROW_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_COL:      start_col_q <= cfg_data[DIM_W-1:0];
				CFG_START_ROW:      start_row_q <= cfg_data[DIM_W-1:0];
				CFG_VISIBLE_WIDTH:  vis_w_q     <= cfg_data[DIM_W-1:0];
				CFG_VISIBLE_HEIGHT: vis_h_q     <= cfg_data[DIM_W-1:0];
				CFG_OUT_WIDTH:      out_w_q     <= cfg_data[DIM_W-1:0];
				CFG_OUT_HEIGHT:     out_h_q     <= cfg_data[DIM_W-1:0];
				CFG_SOURCE_PITCH:   pitch_q     <= cfg_data;
				CFG_DEST_ROW_GAP:   gap_q       <= cfg_data[DIM_W-1:0];
			endcase
		end
	end

	// Per-frame step division, both axes in parallel
	nnbs_div #(.NUM_W(NUM_W), .DEN_W(DIM_W)) u_col_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_frame),
		.dividend ({vis_w_q, {FB{1'b0}}}),
		.divisor  (ow),
		.quotient (col_quo),
		.busy     (col_busy)
	);

	nnbs_div #(.NUM_W(NUM_W), .DEN_W(DIM_W)) u_row_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_frame),
		.dividend ({vis_h_q, {FB{1'b0}}}),
		.divisor  (oh),
		.quotient (row_quo),
		.busy     (row_busy)
	);

	assign sts.div_busy      = col_busy || row_busy;
	assign sts.frame_running = frame_running_q;

	// Position bookkeeping for the pixel being finished
	assign cols_dec   = cols_left_q - 1'b1;
	assign rows_dec   = rows_left_q - 1'b1;
	assign row_last   = (cols_dec == '0);
	assign frame_last = row_last && (rows_dec == '0);
	assign dest_inc   = dest_q + 1'b1;

	// Frame state: set up at frame start, advance per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_step_q      <= '0;
			row_step_q      <= '0;
			col_accum_q     <= '0;
			row_accum_q     <= '0;
			cols_left_q     <= '0;
			rows_left_q     <= '0;
			dest_q          <= '0;
			frame_running_q <= 1'b0;
		end else if (cmd.start_frame) begin
			col_accum_q     <= ACC_W'({start_col_q, {FB{1'b0}}});
			row_accum_q     <= ACC_W'({start_row_q, {FB{1'b0}}});
			cols_left_q     <= ow;
			rows_left_q     <= oh;
			dest_q          <= '0;
			frame_running_q <= 1'b1;
		end else if (cmd.step_load) begin
			col_step_q <= col_quo;
			row_step_q <= row_quo;
		end else if (cmd.out_load) begin
			if (row_last) begin
				col_accum_q <= ACC_W'({start_col_q, {FB{1'b0}}});
				row_accum_q <= row_accum_q + ACC_W'(row_step_q);
				cols_left_q <= ow;
				rows_left_q <= rows_dec;
				dest_q      <= dest_inc + DEST_W'(gap_q);
				if (rows_dec == '0) begin
					frame_running_q <= 1'b0;
				end
			end else begin
				col_accum_q <= col_accum_q + ACC_W'(col_step_q);
				cols_left_q <= cols_dec;
				dest_q      <= dest_inc;
			end
		end
	end

	// Source index: whole row times pitch, then plus whole column
	assign idx_sum = IDX_W'(prod_s1) + IDX_W'(col_int_s1);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1    <= PROD_W'(row_accum_q[ACC_W-1:FB]) * PROD_W'(pitch_q);
			col_int_s1 <= col_accum_q[ACC_W-1:FB];
		end
		if (cmd.add_en) begin
			idx_s2     <= idx_sum;
			outside_s2 <= idx_sum >= IDX_W'(STORE_DEPTH);
		end
	end

	// Frame store: loads write, emits read at the held index
	assign load_ok = 32'(load_index) < 32'(STORE_DEPTH);

	nnbs_ram #(.WIDTH(PIXEL_W), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.ram_we && load_ok),
		.waddr (AW'(load_index)),
		.wdata (load_pixel),
		.raddr (idx_s2[AW-1:0]),
		.rdata (rdata)
	);

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pixel     <= outside_s2 ? '0 : rdata;
			dest_address  <= dest_q;
			row_end       <= row_last;
			frame_end     <= frame_last;
			outside_store <= outside_s2;
		end
	end

	// The last pixel of a frame closes the frame
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && frame_last) |=> !frame_running_q)
		else $error("frame still running after its last pixel");

	// Results are produced only inside a running frame
	a_load_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> frame_running_q)
		else $error("result outside a frame");

	// Row and column counters stay nonzero while a frame runs
	a_counts_live: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_running_q && !cmd.start_frame) |-> (cols_left_q != '0 && rows_left_q != '0))
		else $error("zero position counter in a running frame");

endmodule

// ----- design/nearest_neighbor_bitmap_scaler_top.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_bitmap_scaler_top
// Nearest-neighbor bitmap scaler. Load items fill a frame store with 16-bit
// source pixels; emit items return the next scaled output pixel in raster
// order with its destination address and row/frame markers.
//
//   Channel   Direction  Handshake              Content
//   s_axis    in         tvalid/tready          tuser: operation; tdata: load
//   m_axis    out        tvalid/tready          tdata, tlast, tuser: result
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A load is one write (one store write port); the input stays ready. An emit
// steps through accept, multiply, add, store read, result load; the first emit
// of a frame adds divider start, one quotient bit per cycle (12 + FRACTION_BITS
// bits) and a step load.
// A stalled output holds the last stage until the output register frees; the
// output register lets a new item be accepted while a result waits.
// Reset is asynchronous; no clearing pass, the store is undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_bitmap_scaler_top #(
	parameter int STORE_DEPTH   = 131072,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [16:0] load_index, [32:17] load_pixel, [39:33] zero
	input  logic [nnbs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// [0] operation
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] out_pixel, [40:16] dest_address, [47:41] zero
	output logic [nnbs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// row_end
	output logic                                m_axis_tlast,
	// [0] frame_end, [1] outside_store
	output logic [nnbs_pkg::M_TUSER_W-1:0]      m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nnbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nnbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import nnbs_pkg::*;

	nnbs_cmd_t          cmd;
	nnbs_sts_t          sts;
	logic [PIXEL_W-1:0] out_pixel;
	logic [DEST_W-1:0]  dest_address;
	logic               frame_end;
	logic               outside_store;

	// Registers take every write
	assign cfg_ready = 1'b1;

	nnbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_op      (s_axis_tuser),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	nnbs_dp #(
		.STORE_DEPTH   (STORE_DEPTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.load_index    (s_axis_tdata[LOAD_IDX_W-1:0]),
		.load_pixel    (s_axis_tdata[LOAD_IDX_W+PIXEL_W-1:LOAD_IDX_W]),
		.out_pixel     (out_pixel),
		.dest_address  (dest_address),
		.row_end       (m_axis_tlast),
		.frame_end     (frame_end),
		.outside_store (outside_store)
	);

	// Pack the result
	assign m_axis_tdata = {{(M_TDATA_W-DEST_W-PIXEL_W){1'b0}}, dest_address, out_pixel};
	assign m_axis_tuser = {outside_store, frame_end};

endmodule
